// ----- hdl/amsp_pkg.sv -----
// shared types, register codes and a constant table for the srgb premultiply block
// the sRGB-to-linear table is built here at elaboration and the linear-to-sRGB
// entries are found here, by exact wide integer arithmetic; no other dependencies
package amsp_pkg;

	localparam int unsigned OUT_LUT_ENTRIES_DEF = 1024;
	localparam int unsigned PIX_W = 32;
	localparam int unsigned CH_W = 8;
	localparam int unsigned LIN_W = 16;
	localparam int unsigned RGB_W = 24;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned BIG_W = 320;

	localparam logic [MODE_W-1:0] MODE_KEEP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ALPHA_BYTE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COMPOSE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMPOSE_COLOR = 2'd1;

	localparam logic [MODE_W-1:0] ALPHA_MODE_RST = MODE_KEEP;
	localparam logic [RGB_W-1:0] COMPOSE_COLOR_RST = 24'hFFFFFF;

	typedef logic [BIG_W-1:0] big_t;
	typedef logic [LIN_W-1:0] lin_rom_t [256];

	function automatic big_t big_pow(input big_t base, input int unsigned e);
		big_t acc;
		acc = big_t'(1);
		for (int unsigned t = 0; t < e; t++) begin
			acc = acc * base;
		end
		return acc;
	endfunction

	// largest L with (L/65535)^5 <= ((1000v+14025)/269025)^12 above the linear toe
	function automatic logic [LIN_W-1:0] lin_value(input int unsigned v);
		big_t rhs;
		big_t lhs;
		big_t k12;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		logic [LIN_W-1:0] res;
		if (longint'(v) * 100000 <= 4045 * 255) begin
			res = LIN_W'((longint'(6553500) * longint'(v)) / 329460);
		end else begin
			k12 = big_pow(big_t'(269025), 12);
			rhs = big_pow(big_t'(1000 * v + 14025), 12) * big_pow(big_t'(65535), 5);
			lo = 0;
			hi = 65535;
			while (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				lhs = big_pow(big_t'(mid), 5) * k12;
				if (lhs <= rhs) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
			res = LIN_W'(lo);
		end
		return res;
	endfunction

	// largest o with out curve at or below i/n1; the toe is searched too
	function automatic logic [CH_W-1:0] out_value(input int unsigned i, input int unsigned n1);
		big_t rhs;
		big_t lhs;
		big_t n5;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		logic toe;
		toe = (longint'(i) * 10000000 <= longint'(31308) * longint'(n1));
		rhs = big_pow(big_t'(i), 5) * big_pow(big_t'(269025), 12);
		n5 = big_pow(big_t'(n1), 5);
		lo = 0;
		hi = 255;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (toe) begin
				lhs = big_t'(mid * 100 * longint'(n1));
				if (lhs <= big_t'(longint'(329460) * longint'(i))) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end else begin
				lhs = big_pow(big_t'(1000 * mid + 14025), 12) * n5;
				if (lhs <= rhs) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
		end
		return CH_W'(lo);
	endfunction

	function automatic lin_rom_t build_lin_rom();
		lin_rom_t rom;
		for (int unsigned k = 0; k < 256; k++) begin
			rom[k] = lin_value(k);
		end
		return rom;
	endfunction

	localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

// ----- hdl/amsp_chan.sv -----
// one color channel of the premultiply pipeline: linear product, table index
// scaling and linear-to-sRGB lookup, three register stages; uses amsp_pkg
module amsp_chan #(
	parameter int unsigned OUT_LUT_ENTRIES = amsp_pkg::OUT_LUT_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic [amsp_pkg::LIN_W-1:0] alin,
	input  logic [amsp_pkg::LIN_W-1:0] clin,
	output logic [amsp_pkg::CH_W-1:0]  chan_out
);
	import amsp_pkg::*;

	localparam int unsigned NW = $clog2(OUT_LUT_ENTRIES + 1);
	localparam int unsigned IDX_W = $clog2(OUT_LUT_ENTRIES);
	localparam int unsigned PROD_W = 2 * LIN_W;
	localparam int unsigned SCL_W = PROD_W + NW;

	typedef logic [CH_W-1:0] out_rom_t [OUT_LUT_ENTRIES];

	function automatic out_rom_t build_out_rom();
		out_rom_t rom;
		for (int unsigned k = 0; k < OUT_LUT_ENTRIES; k++) begin
			rom[k] = out_value(k, OUT_LUT_ENTRIES - 1);
		end
		return rom;
	endfunction

	localparam out_rom_t OUT_ROM = build_out_rom();

	logic [PROD_W-1:0] prod_s3;
	logic [SCL_W-1:0]  scaled_s4;
	logic [NW-1:0]     idx_top;
	logic [IDX_W-1:0]  idx;
	logic [CH_W-1:0]   chan_s5;

	// index = product * entries / 2^32, clamped to the last entry
	assign idx_top = scaled_s4[PROD_W +: NW];
	assign idx = (idx_top >= NW'(OUT_LUT_ENTRIES)) ? IDX_W'(OUT_LUT_ENTRIES - 1)
		: idx_top[IDX_W-1:0];

	always_ff @(posedge clk) begin
		prod_s3   <= PROD_W'(alin) * PROD_W'(clin);
		scaled_s4 <= SCL_W'(prod_s3) * SCL_W'(OUT_LUT_ENTRIES);
		chan_s5   <= OUT_ROM[idx];
	end

	assign chan_out = chan_s5;

endmodule

// ----- hdl/alpha_merge_srgb_premultiply.sv -----
// alpha merge and sRGB linear-light premultiply of ARGB8888 pixels
// top level: config registers, merge and linearize stages, three channel pipes
// depends on amsp_pkg and amsp_chan
//
// usage: a pixel transaction is taken on each rising edge with start high and
// busy low; busy is always low, so one pixel per clock is sustained. color_pixel
// and alpha_byte are sampled with start. the result shows on premult_pixel with
// done high for exactly one cycle, after the five stages merge, sRGB-to-linear,
// product, table index scaling and linear-to-sRGB lookup, and is taken at the
// edge that ends that cycle. the receiver cannot stall and nothing waits on it:
// results leave in input order, one per accepted pixel.
// config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high. index 0 is alpha_mode, index 1 is compose_color, other indexes are
// ignored. write config only while no pixel is in flight.
// reset clears the stage valid bits (no done strobes) and sets alpha_mode to
// keep pixel alpha and compose_color to white; the tables are constant logic.
module alpha_merge_srgb_premultiply #(
	parameter int unsigned OUT_LUT_ENTRIES = amsp_pkg::OUT_LUT_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [amsp_pkg::PIX_W-1:0]      color_pixel,
	input  logic [amsp_pkg::CH_W-1:0]       alpha_byte,
	output logic                            done,
	output logic [amsp_pkg::PIX_W-1:0]      premult_pixel,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [amsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [amsp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import amsp_pkg::*;

	logic [MODE_W-1:0] alpha_mode_q;
	logic [RGB_W-1:0]  compose_color_q;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [PIX_W-1:0]  px_merged;
	logic [PIX_W-1:0]  px_s1;
	logic [CH_W-1:0]   a_s2, a_s3, a_s4, a_s5;
	logic [LIN_W-1:0]  alin_s2, rlin_s2, glin_s2, blin_s2;
	logic [CH_W-1:0]   r_out, g_out, b_out;
	logic              accept;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_mode_q    <= ALPHA_MODE_RST;
			compose_color_q <= COMPOSE_COLOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ALPHA_MODE:    alpha_mode_q <= cfg_data[MODE_W-1:0];
				REG_COMPOSE_COLOR: compose_color_q <= cfg_data[RGB_W-1:0];
				default: ;
			endcase
		end
	end

	// unused mode code keeps the pixel as is
	always_comb begin
		unique case (alpha_mode_q)
			MODE_ALPHA_BYTE: px_merged = {alpha_byte, color_pixel[RGB_W-1:0]};
			MODE_COMPOSE:    px_merged = {alpha_byte, compose_color_q};
			default:         px_merged = color_pixel;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		px_s1   <= px_merged;
		a_s2    <= px_s1[31:24];
		alin_s2 <= LIN_ROM[px_s1[31:24]];
		rlin_s2 <= LIN_ROM[px_s1[23:16]];
		glin_s2 <= LIN_ROM[px_s1[15:8]];
		blin_s2 <= LIN_ROM[px_s1[7:0]];
		a_s3    <= a_s2;
		a_s4    <= a_s3;
		a_s5    <= a_s4;
	end

	amsp_chan #(.OUT_LUT_ENTRIES(OUT_LUT_ENTRIES)) u_chan_r (
		.clk(clk), .alin(alin_s2), .clin(rlin_s2), .chan_out(r_out)
	);

	amsp_chan #(.OUT_LUT_ENTRIES(OUT_LUT_ENTRIES)) u_chan_g (
		.clk(clk), .alin(alin_s2), .clin(glin_s2), .chan_out(g_out)
	);

	amsp_chan #(.OUT_LUT_ENTRIES(OUT_LUT_ENTRIES)) u_chan_b (
		.clk(clk), .alin(alin_s2), .clin(blin_s2), .chan_out(b_out)
	);

	assign done = v_s5;
	assign premult_pixel = {a_s5, r_out, g_out, b_out};

	// every strobe traces back to an accepted transaction
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("done without a matching accepted transaction");

	// the output alpha is the merged alpha of the same transaction
	a_alpha_passes: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> premult_pixel[31:24] == $past(px_s1[31:24], 4))
		else $error("output alpha differs from merged alpha");

	// zero alpha premultiplies every channel to zero
	a_zero_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(done && premult_pixel[31:24] == 8'd0) |-> premult_pixel[23:0] == 24'd0)
		else $error("nonzero color with zero alpha");

endmodule
